### sv/ate_pkg.sv
// Shared types, constants and colour functions of the text terminal engine.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package ate_pkg;

  localparam int PARAM_DEPTH = 16;
  localparam int PARAM_AW    = $clog2(PARAM_DEPTH);
  localparam int POS_W       = 13;
  localparam int DIM_W       = 14;
  localparam int RGB_W       = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int Q_DEPTH     = 2;

  localparam logic [DIM_W-1:0] SCR_MAX   = 14'd8192;
  localparam logic [RGB_W-1:0] RESET_FG  = 24'hAAAAAA;
  localparam logic [3:0]       RESET_FW  = 4'd8;
  localparam logic [5:0]       RESET_FH  = 6'd16;
  localparam logic [DIM_W-1:0] RESET_SW  = 14'd1024;
  localparam logic [DIM_W-1:0] RESET_SH  = 14'd768;
  localparam logic [15:0]      NUM_SAT   = 16'hFFFF;

  // Character codes
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRKT  = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_FIVE   = 8'h35;
  localparam logic [7:0] CH_LOW_M  = 8'h6D;
  localparam logic [7:0] CH_UP_J   = 8'h4A;
  localparam logic [7:0] CH_UP_H   = 8'h48;
  localparam logic [7:0] CH_LOW_S  = 8'h73;
  localparam logic [7:0] CH_LOW_H  = 8'h68;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;

  // Parser modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_PARAM  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FONT_W = 3'd0,
    CFG_FONT_H = 3'd1,
    CFG_SCR_W  = 3'd2,
    CFG_SCR_H  = 3'd3,
    CFG_DEF_FG = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_GLYPH        = 2'd0,
    CMD_CLEAR_CELL   = 2'd1,
    CMD_SCROLL       = 2'd2,
    CMD_CLEAR_SCREEN = 2'd3
  } cmd_kind_t;

  typedef enum logic [2:0] {
    BC_PRINT = 3'd0,
    BC_CARET = 3'd1,
    BC_ESC   = 3'd2,
    BC_CR    = 3'd3,
    BC_LF    = 3'd4,
    BC_TAB   = 3'd5,
    BC_BS    = 3'd6
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  char_byte;
    byte_class_t cls;
    logic        letter;
    logic [7:0]  alt_glyph;
  } item_t;

  typedef struct packed {
    logic [3:0]       font_w;
    logic [5:0]       font_h;
    logic [DIM_W-1:0] scr_w;
    logic [DIM_W-1:0] scr_h;
    logic [RGB_W-1:0] def_fg;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [7:0]       glyph;
    logic [RGB_W-1:0] fore;
    logic [RGB_W-1:0] back;
    logic             cursor_on;
    logic             last;
  } cmd_t;

  function automatic logic [RGB_W-1:0] palette(input logic [3:0] idx);
    logic [RGB_W-1:0] c;
    case (idx)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'hAA0000;
      4'd2:    c = 24'h00AA00;
      4'd3:    c = 24'hAA5500;
      4'd4:    c = 24'h0000AA;
      4'd5:    c = 24'hAA00AA;
      4'd6:    c = 24'h00AAAA;
      4'd7:    c = 24'hAAAAAA;
      4'd8:    c = 24'h555555;
      4'd9:    c = 24'hFF5555;
      4'd10:   c = 24'h55FF55;
      4'd11:   c = 24'hFFFF55;
      4'd12:   c = 24'h5555FF;
      4'd13:   c = 24'hFF55FF;
      4'd14:   c = 24'h55FFFF;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  // 16-colour SGR codes: 30-37 (bold brightens), 40-47, 90-97, 100-107
  function automatic logic [RGB_W-1:0] color16(input logic [6:0] code, input logic bold);
    logic [6:0] idx;
    if (code >= 7'd30 && code <= 7'd37) begin
      idx = code - 7'd30 + (bold ? 7'd8 : 7'd0);
    end else if (code >= 7'd40 && code <= 7'd47) begin
      idx = code - 7'd40;
    end else if (code >= 7'd90 && code <= 7'd97) begin
      idx = code - 7'd82;
    end else begin
      idx = code - 7'd92;
    end
    return palette(idx[3:0]);
  endfunction

  function automatic logic [7:0] cube_level(input logic [2:0] v);
    return (v == 3'd0) ? 8'd0 : (8'(v) * 8'd40 + 8'd55);
  endfunction

  // Division by 36 and 6 over the 216-entry cube done by compare chains
  function automatic logic [RGB_W-1:0] color256(input logic [15:0] n,
                                                input logic [RGB_W-1:0] dflt);
    logic [7:0] k;
    logic [7:0] rem;
    logic [7:0] gray;
    logic [2:0] r;
    logic [2:0] g;
    logic [7:0] b;
    logic [RGB_W-1:0] res;
    k = n[7:0] - 8'd16;
    if      (k >= 8'd180) r = 3'd5;
    else if (k >= 8'd144) r = 3'd4;
    else if (k >= 8'd108) r = 3'd3;
    else if (k >= 8'd72)  r = 3'd2;
    else if (k >= 8'd36)  r = 3'd1;
    else                  r = 3'd0;
    rem = k - 8'(r) * 8'd36;
    if      (rem >= 8'd30) g = 3'd5;
    else if (rem >= 8'd24) g = 3'd4;
    else if (rem >= 8'd18) g = 3'd3;
    else if (rem >= 8'd12) g = 3'd2;
    else if (rem >= 8'd6)  g = 3'd1;
    else                   g = 3'd0;
    b = rem - 8'(g) * 8'd6;
    gray = (n[7:0] - 8'd232) * 8'd10 + 8'd8;
    if (n < 16'd16) begin
      res = palette(n[3:0]);
    end else if (n <= 16'd231) begin
      res = {cube_level(r), cube_level(g), cube_level(b[2:0])};
    end else if (n <= 16'd255) begin
      res = {gray, gray, gray};
    end else begin
      res = dflt;
    end
    return res;
  endfunction

endpackage

### sv/ate_front.sv
// Front end: takes character beats and classifies each byte for the executor.
// Depends on ate_pkg.
`timescale 1ns / 1ps

module ate_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,    // [7:0] char_byte
  output logic          push_valid,
  input  logic          push_ready,
  output ate_pkg::item_t push_item
);

  logic           fr_valid_r, fr_valid_nxt;
  ate_pkg::item_t fr_item_r, fr_item_nxt;
  ate_pkg::item_t cls_item;
  logic [7:0]     c;

  // Byte classification
  always_comb begin
    c = in_tdata;
    cls_item.char_byte = c;
    cls_item.letter    = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    cls_item.alt_glyph = (c == ate_pkg::CH_DEL) ? ate_pkg::CH_QMARK : (c + 8'h40);
    unique case (c)
      ate_pkg::CH_ESC: cls_item.cls = ate_pkg::BC_ESC;
      ate_pkg::CH_CR:  cls_item.cls = ate_pkg::BC_CR;
      ate_pkg::CH_LF:  cls_item.cls = ate_pkg::BC_LF;
      ate_pkg::CH_TAB: cls_item.cls = ate_pkg::BC_TAB;
      ate_pkg::CH_BS:  cls_item.cls = ate_pkg::BC_BS;
      default: begin
        if (c < ate_pkg::CH_SPACE || c == ate_pkg::CH_DEL) cls_item.cls = ate_pkg::BC_CARET;
        else cls_item.cls = ate_pkg::BC_PRINT;
      end
    endcase
  end

  assign in_tready  = !fr_valid_r || push_ready;
  assign push_valid = fr_valid_r;
  assign push_item  = fr_item_r;

  // Holding stage
  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_item_nxt  = fr_item_r;
    if (in_tvalid && in_tready) begin
      fr_valid_nxt = 1'b1;
      fr_item_nxt  = cls_item;
    end else if (push_ready) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_item_r <= fr_item_nxt;
  end

endmodule

### sv/ate_fifo.sv
// Short queue of classified items between the front end and the executor.
// Depends on ate_pkg.
`timescale 1ns / 1ps

module ate_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  ate_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ate_pkg::item_t pop_item
);

  localparam int PW = $clog2(ate_pkg::Q_DEPTH);

  ate_pkg::item_t mem_r [ate_pkg::Q_DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != (PW+1)'(ate_pkg::Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count
  always_comb begin
    wr_nxt  = do_push ? PW'(wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop  ? PW'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) mem_r[wr_r] <= push_item;
  end

endmodule

### sv/ate_back.sv
// Executor: parser state, cursor, colours, SGR walk, tab division and the
// command output register. Depends on ate_pkg.
`timescale 1ns / 1ps

module ate_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ate_pkg::cfg_t  cfg,
  input  logic           q_valid,
  output logic           q_ready,
  input  ate_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output ate_pkg::cmd_t  out_cmd
);

  localparam int PW = ate_pkg::POS_W;
  localparam int DW = ate_pkg::DIM_W;
  localparam int AW = ate_pkg::PARAM_AW;
  localparam int CW = $clog2(PW + 1);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_GLYPH  = 9'b000000010,
    ST_DIV    = 9'b000000100,
    ST_TABMUL = 9'b000001000,
    ST_FIT    = 9'b000010000,
    ST_PEND   = 9'b000100000,
    ST_SCRL   = 9'b001000000,
    ST_SGR    = 9'b010000000,
    ST_NUM    = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    PH_VAL, PH_MODE, PH_IDX, PH_R, PH_G, PH_B
  } phase_t;

  state_t state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [7:0]    pbuf_r [ate_pkg::PARAM_DEPTH];
  logic [7:0]    pbuf_nxt [ate_pkg::PARAM_DEPTH];
  logic [AW-1:0] pcnt_r, pcnt_nxt;
  logic [PW-1:0] col_r, col_nxt, row_r, row_nxt, line_r, line_nxt;
  logic [23:0]   fg_r, fg_nxt, bg_r, bg_nxt;
  logic          bold_r, bold_nxt, cen_r, cen_nxt;
  logic [7:0]    g_r, g_nxt, sec_r, sec_nxt;
  logic          sec_pend_r, sec_pend_nxt;
  logic [PW-1:0] nx_r, nx_nxt;
  logic [PW+1:0] ny_r, ny_nxt;
  logic          pend_r, pend_nxt, scroll_r, scroll_nxt;
  ate_pkg::cmd_t pcmd_r, pcmd_nxt;
  logic [PW-1:0] dnum_r, dnum_nxt, dquo_r, dquo_nxt;
  logic [3:0]    drem_r, drem_nxt;
  logic [CW-1:0] dcnt_r, dcnt_nxt;
  logic [AW-1:0] sp_r, sp_nxt;
  logic [15:0]   sv_r, sv_nxt;
  phase_t        ph_r, ph_nxt;
  logic          sfg_r, sfg_nxt;
  logic [7:0]    sr_r, sr_nxt, sg_r, sg_nxt;
  logic          ov_r, ov_nxt;
  ate_pkg::cmd_t oc_r, oc_nxt;

  logic [3:0]    fw;
  logic [5:0]    fh;
  logic [DW-1:0] w_eff, h_eff;
  logic          slot_free;

  assign fw        = cfg.font_w;
  assign fh        = cfg.font_h;
  assign w_eff     = (cfg.scr_w > ate_pkg::SCR_MAX) ? ate_pkg::SCR_MAX : cfg.scr_w;
  assign h_eff     = (cfg.scr_h > ate_pkg::SCR_MAX) ? ate_pkg::SCR_MAX : cfg.scr_h;
  assign slot_free = !ov_r || out_ready;
  assign q_ready   = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_cmd   = oc_r;

  always_comb begin
    logic [7:0]    c;
    logic [PW+1:0] row_down;
    logic [DW:0]   adv;
    logic [4:0]    shifted;
    logic [DW-1:0] qq;
    logic [17:0]   prod;
    logic [7:0]    pb;
    logic          inr, digit, semi;
    logic [AW-1:0] sp_semi;
    logic [20:0]   acc;
    logic [23:0]   col256;
    logic          eoc;

    state_nxt = state_r;   mode_nxt = mode_r;   pbuf_nxt = pbuf_r;
    pcnt_nxt = pcnt_r;     col_nxt = col_r;     row_nxt = row_r;
    line_nxt = line_r;     fg_nxt = fg_r;       bg_nxt = bg_r;
    bold_nxt = bold_r;     cen_nxt = cen_r;     g_nxt = g_r;
    sec_nxt = sec_r;       sec_pend_nxt = sec_pend_r;
    nx_nxt = nx_r;         ny_nxt = ny_r;       pend_nxt = pend_r;
    scroll_nxt = scroll_r; pcmd_nxt = pcmd_r;   dnum_nxt = dnum_r;
    dquo_nxt = dquo_r;     drem_nxt = drem_r;   dcnt_nxt = dcnt_r;
    sp_nxt = sp_r;         sv_nxt = sv_r;       ph_nxt = ph_r;
    sfg_nxt = sfg_r;       sr_nxt = sr_r;       sg_nxt = sg_r;
    ov_nxt = ov_r && !out_ready;
    oc_nxt = oc_r;

    c        = q_item.char_byte;
    row_down = (PW+2)'(row_r) + (PW+2)'(fh);
    adv      = (DW+1)'(col_r) + (DW+1)'(fw);
    shifted  = {drem_r, dnum_r[PW-1]};
    qq       = (DW'(dquo_r) + DW'(8)) & ~DW'(7);
    prod     = 18'(qq) * 18'(fw);
    pb       = pbuf_r[sp_r];
    inr      = (sp_r < pcnt_r);
    digit    = inr && (pb >= ate_pkg::CH_ZERO) && (pb <= ate_pkg::CH_NINE);
    semi     = inr && (pb == ate_pkg::CH_SEMI);
    sp_semi  = sp_r + AW'(semi);
    acc      = 21'(sv_r) * 21'd10 + 21'(pb - ate_pkg::CH_ZERO);
    col256   = ate_pkg::color256(sv_r, cfg.def_fg);
    eoc      = 1'b0;

    pcmd_nxt.fore      = fg_r;
    pcmd_nxt.back      = bg_r;
    pcmd_nxt.cursor_on = cen_r;
    pcmd_nxt.last      = 1'b0;

    unique case (state_r)
      // Take the next item and start its action
      ST_IDLE: begin
        if (q_valid && fw != 4'd0 && fh != 6'd0) begin
          pend_nxt     = 1'b0;
          sec_pend_nxt = 1'b0;
          scroll_nxt   = 1'b0;
          if (mode_r == ate_pkg::MODE_ESC) begin
            if (c == ate_pkg::CH_LBRKT) begin
              pcnt_nxt = '0;
              mode_nxt = ate_pkg::MODE_PARAM;
            end else begin
              mode_nxt = ate_pkg::MODE_NORMAL;
            end
          end else if (mode_r == ate_pkg::MODE_PARAM) begin
            if (q_item.letter) begin
              mode_nxt = ate_pkg::MODE_NORMAL;
              unique case (c)
                ate_pkg::CH_LOW_M: state_nxt = ST_SGR;
                ate_pkg::CH_UP_J: begin
                  if (pcnt_r != '0 && pbuf_r[0] == ate_pkg::CH_TWO) begin
                    pcmd_nxt.kind  = ate_pkg::CMD_CLEAR_SCREEN;
                    pcmd_nxt.pos_x = '0;
                    pcmd_nxt.pos_y = '0;
                    pcmd_nxt.glyph = '0;
                    pend_nxt  = 1'b1;
                    col_nxt   = '0;
                    row_nxt   = '0;
                    line_nxt  = '0;
                    bold_nxt  = 1'b0;
                    state_nxt = ST_PEND;
                  end
                end
                ate_pkg::CH_UP_H: begin
                  col_nxt = '0;
                  row_nxt = '0;
                end
                ate_pkg::CH_LOW_S: line_nxt = row_r;
                ate_pkg::CH_LOW_H, ate_pkg::CH_LOW_L: begin
                  if (pcnt_r == AW'(3) && pbuf_r[0] == ate_pkg::CH_QMARK &&
                      pbuf_r[1] == ate_pkg::CH_TWO && pbuf_r[2] == ate_pkg::CH_FIVE)
                    cen_nxt = (c == ate_pkg::CH_LOW_H);
                end
                default: ;
              endcase
            end else if (pcnt_r < AW'(ate_pkg::PARAM_DEPTH - 1)) begin
              pbuf_nxt[pcnt_r] = c;
              pcnt_nxt = pcnt_r + 1'b1;
            end
          end else begin
            nx_nxt = col_r;
            ny_nxt = (PW+2)'(row_r);
            unique case (q_item.cls)
              ate_pkg::BC_PRINT: begin
                g_nxt     = c;
                state_nxt = ST_GLYPH;
              end
              ate_pkg::BC_CARET: begin
                g_nxt        = ate_pkg::CH_CARET;
                sec_nxt      = q_item.alt_glyph;
                sec_pend_nxt = 1'b1;
                state_nxt    = ST_GLYPH;
              end
              ate_pkg::BC_ESC: begin
                mode_nxt  = ate_pkg::MODE_ESC;
                state_nxt = ST_FIT;
              end
              ate_pkg::BC_CR: begin
                nx_nxt    = '0;
                state_nxt = ST_FIT;
              end
              ate_pkg::BC_LF: begin
                nx_nxt    = '0;
                ny_nxt    = row_down;
                line_nxt  = (row_down > (PW+2)'({PW{1'b1}})) ? {PW{1'b1}} : row_down[PW-1:0];
                state_nxt = ST_FIT;
              end
              ate_pkg::BC_TAB: begin
                dnum_nxt  = col_r;
                dquo_nxt  = '0;
                drem_nxt  = '0;
                dcnt_nxt  = CW'(PW);
                state_nxt = ST_DIV;
              end
              ate_pkg::BC_BS: begin
                pcmd_nxt.kind  = ate_pkg::CMD_CLEAR_CELL;
                pcmd_nxt.glyph = '0;
                if (col_r >= PW'(fw)) begin
                  nx_nxt         = col_r - PW'(fw);
                  pcmd_nxt.pos_x = col_r - PW'(fw);
                  pcmd_nxt.pos_y = row_r;
                  pend_nxt       = 1'b1;
                end else if (row_r > line_r) begin
                  ny_nxt = (row_r >= PW'(fh)) ? (PW+2)'(row_r - PW'(fh)) : '0;
                  nx_nxt = (w_eff >= DW'(fw)) ? PW'(w_eff - DW'(fw)) : '0;
                  pcmd_nxt.pos_x = (w_eff >= DW'(fw)) ? PW'(w_eff - DW'(fw)) : '0;
                  pcmd_nxt.pos_y = (row_r >= PW'(fh)) ? (row_r - PW'(fh)) : '0;
                  pend_nxt       = 1'b1;
                end
                state_nxt = ST_FIT;
              end
              default: state_nxt = ST_IDLE;
            endcase
          end
        end
      end

      // Glyph at the cursor, then advance with wrap
      ST_GLYPH: begin
        pcmd_nxt.kind  = ate_pkg::CMD_GLYPH;
        pcmd_nxt.pos_x = col_r;
        pcmd_nxt.pos_y = row_r;
        pcmd_nxt.glyph = g_r;
        pend_nxt       = 1'b1;
        if (adv >= (DW+1)'(w_eff)) begin
          nx_nxt = '0;
          ny_nxt = row_down;
        end else begin
          nx_nxt = adv[PW-1:0];
          ny_nxt = (PW+2)'(row_r);
        end
        state_nxt = ST_FIT;
      end

      // Restoring division of the column by the font width, one bit a cycle
      ST_DIV: begin
        if (shifted >= 5'(fw)) begin
          drem_nxt = 4'(shifted - 5'(fw));
          dquo_nxt = {dquo_r[PW-2:0], 1'b1};
        end else begin
          drem_nxt = shifted[3:0];
          dquo_nxt = {dquo_r[PW-2:0], 1'b0};
        end
        dnum_nxt = {dnum_r[PW-2:0], 1'b0};
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == CW'(1)) state_nxt = ST_TABMUL;
      end

      // Next multiple of eight cells
      ST_TABMUL: begin
        if (prod >= 18'(w_eff)) begin
          nx_nxt = '0;
          ny_nxt = row_down;
        end else begin
          nx_nxt = prod[PW-1:0];
          ny_nxt = (PW+2)'(row_r);
        end
        state_nxt = ST_FIT;
      end

      // Keep the cell row on screen, scrolling once if needed
      ST_FIT: begin
        col_nxt = nx_r;
        if (ny_r + (PW+2)'(fh) > (PW+2)'(h_eff)) begin
          scroll_nxt = 1'b1;
          row_nxt    = (h_eff >= DW'(fh)) ? PW'(h_eff - DW'(fh)) : '0;
        end else begin
          scroll_nxt = 1'b0;
          row_nxt    = ny_r[PW-1:0];
        end
        if (pend_r) state_nxt = ST_PEND;
        else if (ny_r + (PW+2)'(fh) > (PW+2)'(h_eff)) state_nxt = ST_SCRL;
        else state_nxt = ST_IDLE;
      end

      ST_PEND: begin
        if (slot_free) begin
          ov_nxt       = 1'b1;
          oc_nxt       = pcmd_r;
          oc_nxt.last  = !scroll_r && !sec_pend_r;
          pend_nxt     = 1'b0;
          if (scroll_r) begin
            state_nxt = ST_SCRL;
          end else if (sec_pend_r) begin
            g_nxt        = sec_r;
            sec_pend_nxt = 1'b0;
            state_nxt    = ST_GLYPH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_SCRL: begin
        if (slot_free) begin
          ov_nxt           = 1'b1;
          oc_nxt.kind      = ate_pkg::CMD_SCROLL;
          oc_nxt.pos_x     = '0;
          oc_nxt.pos_y     = '0;
          oc_nxt.glyph     = '0;
          oc_nxt.fore      = fg_r;
          oc_nxt.back      = bg_r;
          oc_nxt.cursor_on = cen_r;
          oc_nxt.last      = !sec_pend_r;
          scroll_nxt       = 1'b0;
          if (sec_pend_r) begin
            g_nxt        = sec_r;
            sec_pend_nxt = 1'b0;
            state_nxt    = ST_GLYPH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_SGR: begin
        if (pcnt_r == '0) begin
          fg_nxt    = cfg.def_fg;
          bg_nxt    = '0;
          bold_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          sp_nxt    = '0;
          sv_nxt    = '0;
          ph_nxt    = PH_VAL;
          state_nxt = ST_NUM;
        end
      end

      // Walk the parameter bytes, one a cycle
      ST_NUM: begin
        if (digit) begin
          sv_nxt = (acc > 21'(ate_pkg::NUM_SAT)) ? ate_pkg::NUM_SAT : acc[15:0];
          sp_nxt = sp_r + 1'b1;
        end else begin
          sv_nxt = '0;
          case (ph_r)
            PH_VAL: begin
              if (sv_r == 16'd0) begin
                fg_nxt   = cfg.def_fg;
                bg_nxt   = '0;
                bold_nxt = 1'b0;
                eoc      = 1'b1;
              end else if (sv_r == 16'd1) begin
                bold_nxt = 1'b1;
                eoc      = 1'b1;
              end else if ((sv_r >= 16'd30 && sv_r <= 16'd37) ||
                           (sv_r >= 16'd90 && sv_r <= 16'd97)) begin
                fg_nxt = ate_pkg::color16(sv_r[6:0], bold_r);
                eoc    = 1'b1;
              end else if ((sv_r >= 16'd40 && sv_r <= 16'd47) ||
                           (sv_r >= 16'd100 && sv_r <= 16'd107)) begin
                bg_nxt = ate_pkg::color16(sv_r[6:0], bold_r);
                eoc    = 1'b1;
              end else if (sv_r == 16'd38 || sv_r == 16'd48) begin
                sfg_nxt = (sv_r == 16'd38);
                sp_nxt  = sp_semi;
                ph_nxt  = PH_MODE;
              end else begin
                eoc = 1'b1;
              end
            end
            PH_MODE: begin
              if (sv_r == 16'd5) begin
                sp_nxt = sp_semi;
                ph_nxt = PH_IDX;
              end else if (sv_r == 16'd2) begin
                sp_nxt = sp_semi;
                ph_nxt = PH_R;
              end else begin
                eoc = 1'b1;
              end
            end
            PH_IDX: begin
              if (sfg_r) fg_nxt = col256;
              else bg_nxt = col256;
              eoc = 1'b1;
            end
            PH_R: begin
              sr_nxt = sv_r[7:0];
              sp_nxt = sp_semi;
              ph_nxt = PH_G;
            end
            PH_G: begin
              sg_nxt = sv_r[7:0];
              sp_nxt = sp_semi;
              ph_nxt = PH_B;
            end
            default: begin
              if (sfg_r) fg_nxt = {sr_r, sg_r, sv_r[7:0]};
              else bg_nxt = {sr_r, sg_r, sv_r[7:0]};
              eoc = 1'b1;
            end
          endcase
          // End of one code: a separator continues the walk
          if (eoc) begin
            sp_nxt = sp_semi;
            ph_nxt = PH_VAL;
            if (!(semi && sp_semi < pcnt_r)) state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      mode_r     <= ate_pkg::MODE_NORMAL;
      pcnt_r     <= '0;
      col_r      <= '0;
      row_r      <= '0;
      line_r     <= '0;
      fg_r       <= ate_pkg::RESET_FG;
      bg_r       <= '0;
      bold_r     <= 1'b0;
      cen_r      <= 1'b1;
      sec_pend_r <= 1'b0;
      pend_r     <= 1'b0;
      scroll_r   <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      pcnt_r     <= pcnt_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      line_r     <= line_nxt;
      fg_r       <= fg_nxt;
      bg_r       <= bg_nxt;
      bold_r     <= bold_nxt;
      cen_r      <= cen_nxt;
      sec_pend_r <= sec_pend_nxt;
      pend_r     <= pend_nxt;
      scroll_r   <= scroll_nxt;
      ov_r       <= ov_nxt;
    end
    pbuf_r <= pbuf_nxt;
    g_r    <= g_nxt;
    sec_r  <= sec_nxt;
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    pcmd_r <= pcmd_nxt;
    dnum_r <= dnum_nxt;
    dquo_r <= dquo_nxt;
    drem_r <= drem_nxt;
    dcnt_r <= dcnt_nxt;
    sp_r   <= sp_nxt;
    sv_r   <= sv_nxt;
    ph_r   <= ph_nxt;
    sfg_r  <= sfg_nxt;
    sr_r   <= sr_nxt;
    sg_r   <= sg_nxt;
    oc_r   <= oc_nxt;
  end

endmodule

### sv/ansi_text_terminal_engine.sv
// Top level of the text terminal engine: configuration registers, front end,
// item queue and executor. Depends on ate_pkg, ate_front, ate_fifo, ate_back.
`timescale 1ns / 1ps

// Usage
//   in_*  : one character byte per beat (in_tdata[7:0]).
//   out_* : display commands, one per beat; out_tuser is the command kind,
//           out_tlast marks the final command caused by one input byte.
//   cfg_* : register writes (font size, screen size, default foreground),
//           always ready; write only while the engine is idle.
// Flow
//   A byte passes a classify stage and a two-entry queue, then the executor
//   takes it. Printable byte: glyph and fit states, then its glyph command
//   from the pend state; a scroll or a caret pair adds states. CR, LF, ESC,
//   backspace: fit, then pend or scroll where needed. Tab: the bit-serial
//   division of the column by the font width (13 steps), the tab stop, fit.
//   SGR terminator: walks up to 15 parameter bytes; others are taken in idle.
// Reset and stalls
//   rst_n (synchronous) restores the register defaults, cursor to the top
//   left, default colours, cursor enabled, parser in normal mode.
//   A stalled receiver holds the output register; the queue and the classify
//   stage keep taking bytes until they are full, then in_tready drops.

module ansi_text_terminal_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,   // pos_x, pos_y, glyph_code, fore_rgb, back_rgb, cursor_on
  output logic [1:0]  out_tuser,   // [1:0] command_kind
  output logic        out_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  ate_pkg::cfg_t  cfg_r, cfg_nxt;
  logic           push_valid, push_ready, pop_valid, pop_ready;
  ate_pkg::item_t push_item, pop_item;
  ate_pkg::cmd_t  cmd;

  assign cfg_ready = 1'b1;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        ate_pkg::CFG_FONT_W: cfg_nxt.font_w = cfg_data[3:0];
        ate_pkg::CFG_FONT_H: cfg_nxt.font_h = cfg_data[5:0];
        ate_pkg::CFG_SCR_W:  cfg_nxt.scr_w  = cfg_data[ate_pkg::DIM_W-1:0];
        ate_pkg::CFG_SCR_H:  cfg_nxt.scr_h  = cfg_data[ate_pkg::DIM_W-1:0];
        ate_pkg::CFG_DEF_FG: cfg_nxt.def_fg = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.font_w <= ate_pkg::RESET_FW;
      cfg_r.font_h <= ate_pkg::RESET_FH;
      cfg_r.scr_w  <= ate_pkg::RESET_SW;
      cfg_r.scr_h  <= ate_pkg::RESET_SH;
      cfg_r.def_fg <= ate_pkg::RESET_FG;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ate_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ate_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  ate_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_item    (pop_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cmd   (cmd)
  );

  // Result beat packing
  assign out_tdata = {5'b0, cmd.cursor_on, cmd.back, cmd.fore, cmd.glyph,
                      cmd.pos_y, cmd.pos_x};
  assign out_tuser = cmd.kind;
  assign out_tlast = cmd.last;

endmodule
